// File: rtl/jsv_pkg.sv
// ----------------------------------------------------------------------------
// jsv_pkg
// Shared types and constants for the JSON syntax validator.
// ----------------------------------------------------------------------------
package jsv_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int SP_W        = $clog2(STACK_DEPTH);

  typedef enum logic [4:0] {
    M_VALUE     = 5'd0,
    M_ARR_FIRST = 5'd1,
    M_OBJ_FIRST = 5'd2,
    M_KEY       = 5'd3,
    M_COLON     = 5'd4,
    M_AFTER     = 5'd5,
    M_LIT       = 5'd6,
    N_MINUS     = 5'd7,
    N_ZERO      = 5'd8,
    N_INT       = 5'd9,
    N_DOT       = 5'd10,
    N_FRAC      = 5'd11,
    N_EXP       = 5'd12,
    N_EXP_SIGN  = 5'd13,
    N_EXP_DIG   = 5'd14,
    S_CHAR      = 5'd16,
    S_ESC       = 5'd17,
    S_HEX       = 5'd18,
    S_UTF8      = 5'd19,
    S_LOW_BS    = 5'd20,
    S_LOW_U     = 5'd21,
    SK_CHAR     = 5'd24,
    SK_ESC      = 5'd25,
    SK_HEX      = 5'd26,
    SK_UTF8     = 5'd27,
    SK_LOW_BS   = 5'd28,
    SK_LOW_U    = 5'd29
  } mode_t;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  localparam logic [1:0] REG_MAX_DEPTH = 2'd0;
  localparam logic [1:0] REG_MAX_BYTES = 2'd1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // literal text by selector and position; zero where past the end
  function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (sel)
      2'd0: case (pos) 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e"; default: c = 8'h00; endcase
      2'd1: case (pos) 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
              default: c = 8'h00; endcase
      2'd2: case (pos) 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l"; default: c = 8'h00; endcase
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] sel);
    return (sel == 2'd1) ? 3'd5 : 3'd4;
  endfunction

endpackage

// File: rtl/jsv_front.sv
// ----------------------------------------------------------------------------
// jsv_front
// Input stage: registers each accepted beat into a two-entry queue.
// ----------------------------------------------------------------------------
module jsv_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  output logic            ready,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output logic            q_valid,
  input  logic            q_ready,
  output jsv_pkg::beat_t  q_beat
);

  jsv_pkg::beat_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign ready   = count != 2'd2;
  assign q_valid = count != 2'd0;
  assign push    = valid && ready;
  assign pop     = q_valid && q_ready;
  assign q_beat  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: data_byte, last: last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) count == 2'd2 |-> !push;
  endproperty
  assert property (p_no_overflow) else $error("queue overflow");

  property p_count_range;
    @(posedge clk) disable iff (rst) count != 2'd3;
  endproperty
  assert property (p_count_range) else $error("queue count out of range");

  property p_pop_only_nonempty;
    @(posedge clk) disable iff (rst) pop |-> count != 2'd0;
  endproperty
  assert property (p_pop_only_nonempty) else $error("pop from empty queue");

endmodule

// File: rtl/jsv_back.sv
// ----------------------------------------------------------------------------
// jsv_back
// Parser: one byte a cycle unless stalled, via the grammar state machine,
// with the container stack, length limit and a registered status output.
// ----------------------------------------------------------------------------
module jsv_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  jsv_pkg::beat_t  q_beat,
  input  logic [6:0]      max_depth,
  input  logic [31:0]     max_document_bytes,
  output logic            valid,
  input  logic            ready,
  output logic [1:0]      status
);

  localparam int SD = jsv_pkg::STACK_DEPTH;

  jsv_pkg::mode_t mode, mode_next;
  logic [SD-1:0]  stack;
  logic [6:0]     depth, depth_next;
  logic [32:0]    bytes_seen;
  logic [2:0]     step, step_next;
  logic [2:0]     lead, lead_next;
  logic [15:0]    hex, hex_next;
  logic           hsp, hsp_next;
  logic           failed;
  logic           fail;

  logic           take;
  logic [7:0]     b;
  logic [32:0]    bytes_inc;
  logic           len_fail;
  logic           push_en, push_kind;
  logic           pop_en;
  logic           top;
  logic           key;
  logic [3:0]     hd;
  logic           hd_ok;
  logic [15:0]    hex_acc;
  logic [7:0]     lo, hi;
  logic           done;
  logic [1:0]     status_next;

  assign q_ready = !valid || ready;
  assign take    = q_valid && q_ready;
  assign b       = q_beat.data;
  assign key     = mode[3];

  assign bytes_inc = (bytes_seen == {33{1'b1}}) ? bytes_seen : bytes_seen + 33'd1;
  assign len_fail  = bytes_inc > {1'b0, max_document_bytes};
  // stack shifts on push and pop, so the innermost kind always sits in bit 0
  assign top = (depth != 7'd0) ? stack[0] : 1'b0;

  always_comb begin
    hd_ok = 1'b1;
    hd    = 4'd0;
    if (jsv_pkg::is_digit(b))          hd = 4'(b - 8'h30);
    else if (b >= "a" && b <= "f")     hd = 4'(b - 8'h57);
    else if (b >= "A" && b <= "F")     hd = 4'(b - 8'h37);
    else                               hd_ok = 1'b0;
  end
  assign hex_acc = {hex[11:0], hd};

  always_comb begin
    lo = 8'h80; hi = 8'hBF;
    case (lead)
      3'd1: lo = 8'hA0;
      3'd2: hi = 8'h9F;
      3'd3: lo = 8'h90;
      3'd4: hi = 8'h8F;
      default: ;
    endcase
  end

  // grammar step; fail set means the document is rejected
  always_comb begin
    logic ends;
    logic open_v;
    logic close_v;
    logic close_kind;
    logic start_v;
    logic after_v;
    mode_next  = mode;
    depth_next = depth;
    step_next  = step;
    lead_next  = lead;
    hex_next   = hex;
    hsp_next   = hsp;
    fail       = 1'b0;
    push_en    = 1'b0;
    push_kind  = 1'b0;
    pop_en     = 1'b0;
    ends       = 1'b0;
    open_v     = 1'b0;
    close_v    = 1'b0;
    close_kind = 1'b0;
    start_v    = 1'b0;
    after_v    = 1'b0;

    unique case (mode)
      jsv_pkg::M_VALUE: start_v = !jsv_pkg::is_ws(b);
      jsv_pkg::M_ARR_FIRST: begin
        if (jsv_pkg::is_ws(b)) ;
        else if (b == "]") begin close_v = 1'b1; close_kind = 1'b0; end
        else start_v = 1'b1;
      end
      jsv_pkg::M_OBJ_FIRST, jsv_pkg::M_KEY: begin
        if (jsv_pkg::is_ws(b)) ;
        else if (b == "\"") begin mode_next = jsv_pkg::SK_CHAR; hsp_next = 1'b0; end
        else if (b == "}" && mode == jsv_pkg::M_OBJ_FIRST) begin
          close_v = 1'b1; close_kind = 1'b1;
        end else fail = 1'b1;
      end
      jsv_pkg::M_COLON: begin
        if (jsv_pkg::is_ws(b)) ;
        else if (b == ":") mode_next = jsv_pkg::M_VALUE;
        else fail = 1'b1;
      end
      jsv_pkg::M_AFTER: after_v = 1'b1;
      jsv_pkg::M_LIT: begin
        if (lead > 3'd2 || step >= jsv_pkg::lit_len(lead[1:0]) ||
            b != jsv_pkg::lit_char(lead[1:0], step)) fail = 1'b1;
        else if (step + 3'd1 == jsv_pkg::lit_len(lead[1:0])) begin
          step_next = 3'd0; lead_next = 3'd0; mode_next = jsv_pkg::M_AFTER;
        end else step_next = step + 3'd1;
      end
      jsv_pkg::N_MINUS: begin
        if (b == "0") mode_next = jsv_pkg::N_ZERO;
        else if (jsv_pkg::is_digit(b)) mode_next = jsv_pkg::N_INT;
        else fail = 1'b1;
      end
      jsv_pkg::N_ZERO, jsv_pkg::N_INT: begin
        if (jsv_pkg::is_digit(b)) fail = (mode == jsv_pkg::N_ZERO);
        else if (b == ".") mode_next = jsv_pkg::N_DOT;
        else if (b == "e" || b == "E") mode_next = jsv_pkg::N_EXP;
        else ends = 1'b1;
      end
      jsv_pkg::N_DOT: begin
        if (jsv_pkg::is_digit(b)) mode_next = jsv_pkg::N_FRAC; else fail = 1'b1;
      end
      jsv_pkg::N_FRAC: begin
        if (jsv_pkg::is_digit(b)) ;
        else if (b == "e" || b == "E") mode_next = jsv_pkg::N_EXP;
        else ends = 1'b1;
      end
      jsv_pkg::N_EXP: begin
        if (b == "+" || b == "-") mode_next = jsv_pkg::N_EXP_SIGN;
        else if (jsv_pkg::is_digit(b)) mode_next = jsv_pkg::N_EXP_DIG;
        else fail = 1'b1;
      end
      jsv_pkg::N_EXP_SIGN: begin
        if (jsv_pkg::is_digit(b)) mode_next = jsv_pkg::N_EXP_DIG; else fail = 1'b1;
      end
      jsv_pkg::N_EXP_DIG: ends = !jsv_pkg::is_digit(b);
      jsv_pkg::S_CHAR, jsv_pkg::SK_CHAR: begin
        if (b == "\"") mode_next = key ? jsv_pkg::M_COLON : jsv_pkg::M_AFTER;
        else if (b == "\\") mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd1});
        else if (b < 8'h20) fail = 1'b1;
        else if (b < 8'h80) ;
        else if (b >= 8'hC2 && b <= 8'hDF) begin
          step_next = 3'd1; lead_next = 3'd0;
          mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd3});
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          step_next = 3'd2;
          lead_next = (b == 8'hE0) ? 3'd1 : (b == 8'hED) ? 3'd2 : 3'd0;
          mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd3});
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          step_next = 3'd3;
          lead_next = (b == 8'hF0) ? 3'd3 : (b == 8'hF4) ? 3'd4 : 3'd0;
          mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd3});
        end else fail = 1'b1;
      end
      jsv_pkg::S_UTF8, jsv_pkg::SK_UTF8: begin
        if (b < lo || b > hi) fail = 1'b1;
        else begin
          lead_next = 3'd0;
          step_next = step - 3'd1;
          if (step == 3'd1) mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd0});
        end
      end
      jsv_pkg::S_ESC, jsv_pkg::SK_ESC: begin
        if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" || b == "n" ||
            b == "r" || b == "t") mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd0});
        else if (b == "u") begin
          step_next = 3'd0; hex_next = 16'd0;
          mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd2});
        end else fail = 1'b1;
      end
      jsv_pkg::S_HEX, jsv_pkg::SK_HEX: begin
        if (!hd_ok) fail = 1'b1;
        else begin
          hex_next  = hex_acc;
          step_next = step + 3'd1;
          if (step == 3'd3) begin
            step_next = 3'd0;
            if (hsp) begin
              if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                hsp_next  = 1'b0;
                mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd0});
              end else fail = 1'b1;
            end else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
              hsp_next  = 1'b1;
              mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd4});
            end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) fail = 1'b1;
            else mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd0});
          end
        end
      end
      jsv_pkg::S_LOW_BS, jsv_pkg::SK_LOW_BS: begin
        if (b == "\\") mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd5}); else fail = 1'b1;
      end
      jsv_pkg::S_LOW_U, jsv_pkg::SK_LOW_U: begin
        if (b == "u") begin
          step_next = 3'd0; hex_next = 16'd0;
          mode_next = jsv_pkg::mode_t'({mode[4:3], 3'd2});
        end else fail = 1'b1;
      end
      default: fail = 1'b1;
    endcase

    // a number ends on a byte that is then taken as the byte after a value
    if (ends) begin
      mode_next = jsv_pkg::M_AFTER;
      after_v   = 1'b1;
    end

    if (after_v && !jsv_pkg::is_ws(b)) begin
      if (depth == 7'd0) fail = 1'b1;
      else if (b == ",") mode_next = top ? jsv_pkg::M_KEY : jsv_pkg::M_VALUE;
      else if (b == "}") begin close_v = 1'b1; close_kind = 1'b1; end
      else if (b == "]") begin close_v = 1'b1; close_kind = 1'b0; end
      else fail = 1'b1;
    end

    if (start_v) begin
      if (b == "{") begin open_v = 1'b1; push_kind = 1'b1; end
      else if (b == "[") begin open_v = 1'b1; push_kind = 1'b0; end
      else if (b == "\"") begin mode_next = jsv_pkg::S_CHAR; hsp_next = 1'b0; end
      else if (b == "t" || b == "f" || b == "n") begin
        mode_next = jsv_pkg::M_LIT;
        lead_next = (b == "t") ? 3'd0 : (b == "f") ? 3'd1 : 3'd2;
        step_next = 3'd1;
      end
      else if (b == "-") mode_next = jsv_pkg::N_MINUS;
      else if (b == "0") mode_next = jsv_pkg::N_ZERO;
      else if (jsv_pkg::is_digit(b)) mode_next = jsv_pkg::N_INT;
      else fail = 1'b1;
    end

    if (open_v) begin
      if ({1'b0, depth} + 8'd1 > {1'b0, max_depth} || 32'(depth) >= SD) fail = 1'b1;
      else begin
        push_en    = 1'b1;
        depth_next = depth + 7'd1;
        mode_next  = push_kind ? jsv_pkg::M_OBJ_FIRST : jsv_pkg::M_ARR_FIRST;
      end
    end

    if (close_v) begin
      if (depth == 7'd0 || top != close_kind) fail = 1'b1;
      else begin
        pop_en     = 1'b1;
        depth_next = depth - 7'd1;
        mode_next  = jsv_pkg::M_AFTER;
      end
    end
  end

  // parse state committed on an accepted beat of a live document
  logic live;
  logic [6:0] depth_eff;
  jsv_pkg::mode_t mode_eff;
  logic failed_eff;
  assign live       = !failed && !len_fail;
  assign failed_eff = failed || len_fail || fail;
  assign mode_eff   = live ? mode_next : mode;
  assign depth_eff  = live ? depth_next : depth;
  assign done = mode_eff == jsv_pkg::M_AFTER || mode_eff == jsv_pkg::N_ZERO ||
                mode_eff == jsv_pkg::N_INT || mode_eff == jsv_pkg::N_FRAC ||
                mode_eff == jsv_pkg::N_EXP_DIG;
  assign status_next = !q_beat.last ? jsv_pkg::ST_BUSY :
                       (!failed_eff && depth_eff == 7'd0 && done) ? jsv_pkg::ST_ACCEPT :
                       jsv_pkg::ST_REJECT;

  always_ff @(posedge clk) begin
    if (take && live && !fail) begin
      if (push_en) stack <= {stack[SD-2:0], push_kind};
      else if (pop_en) stack <= {1'b0, stack[SD-1:1]};
    end
    if (take) status <= status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      mode       <= jsv_pkg::M_VALUE;
      depth      <= 7'd0;
      bytes_seen <= 33'd0;
      step       <= 3'd0;
      lead       <= 3'd0;
      hex        <= 16'd0;
      hsp        <= 1'b0;
      failed     <= 1'b0;
    end else begin
      if (take) valid <= 1'b1;
      else if (ready) valid <= 1'b0;
      if (take) begin
        if (q_beat.last) begin
          mode       <= jsv_pkg::M_VALUE;
          depth      <= 7'd0;
          bytes_seen <= 33'd0;
          step       <= 3'd0;
          lead       <= 3'd0;
          hex        <= 16'd0;
          hsp        <= 1'b0;
          failed     <= 1'b0;
        end else begin
          bytes_seen <= bytes_inc;
          failed     <= failed_eff;
          if (live && !fail) begin
            mode  <= mode_next;
            depth <= depth_next;
            step  <= step_next;
            lead  <= lead_next;
            hex   <= hex_next;
            hsp   <= hsp_next;
          end
        end
      end
    end
  end

  property p_depth_bound;
    @(posedge clk) disable iff (rst) 32'(depth) <= SD;
  endproperty
  assert property (p_depth_bound) else $error("depth beyond stack");

  property p_last_resets;
    @(posedge clk) disable iff (rst) take && q_beat.last |=> depth == 7'd0 && !failed;
  endproperty
  assert property (p_last_resets) else $error("document state not cleared");

  property p_busy_not_last;
    @(posedge clk) disable iff (rst) take && !q_beat.last |=> status == jsv_pkg::ST_BUSY;
  endproperty
  assert property (p_busy_not_last) else $error("verdict on non-final beat");

  property p_fail_sticky;
    @(posedge clk) disable iff (rst) failed && !(take && q_beat.last) |=> failed;
  endproperty
  assert property (p_fail_sticky) else $error("failure not sticky");

endmodule

// File: rtl/json_syntax_validator.sv
// ----------------------------------------------------------------------------
// json_syntax_validator
// Strict streaming JSON syntax checker with an APB register port.
// ----------------------------------------------------------------------------
// One byte beat in gives one status beat out; a sustained rate of one byte
// per clock unless out_ready stalls, set by the combinational grammar step
// in the parser. Beats are registered in the input queue, then in the
// parser's output register. Status is 0 until the beat marked last, which
// carries 1 (accepted) or 2 (rejected). Registers: max_depth at 0x0,
// max_document_bytes at 0x4; write them only while no document is in flight.
module json_syntax_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0]     max_depth;
  logic [31:0]    max_document_bytes;
  logic           q_valid;
  logic           q_ready;
  jsv_pkg::beat_t q_beat;
  logic           wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth          <= 7'd64;
      max_document_bytes <= 32'hFFFF_FFFF;
    end else if (wr) begin
      case (paddr[2])
        jsv_pkg::REG_MAX_DEPTH[0]: max_depth <= pwdata[6:0];
        default:                   max_document_bytes <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      jsv_pkg::REG_MAX_DEPTH[0]: prdata = {25'd0, max_depth};
      default:                   prdata = max_document_bytes;
    endcase
  end

  jsv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .valid    (in_valid),
    .ready    (in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_beat   (q_beat)
  );

  jsv_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_beat            (q_beat),
    .max_depth         (max_depth),
    .max_document_bytes(max_document_bytes),
    .valid             (out_valid),
    .ready             (out_ready),
    .status            (status)
  );

endmodule

// File: tb/sv/json_syntax_validator_test.sv
// ----------------------------------------------------------------------------
// json_syntax_validator_test
// Streams JSON documents through the validator one byte beat at a time.
// A behavioural predictor tracks grammar, nesting, length and string state;
// status beats are checked against it unless a directed row gives its own.
// Runs a short directed table, then random well-formed and damaged
// documents under several limit settings and back-pressure patterns.
// ----------------------------------------------------------------------------
module json_syntax_validator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WATCHDOG   = 3000;
  localparam int          RAND_BEATS = 1350;
  localparam int          N_PHASES   = 6;
  localparam logic [7:0]  QUOTE      = 8'h22;
  localparam logic [7:0]  BSL        = 8'h5C;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  json_syntax_validator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  jsv_pkg::mode_t                  pmode;
  logic [jsv_pkg::STACK_DEPTH-1:0] kinds;      // 1 = object
  int unsigned                     depth;
  logic [32:0]                     nbytes;
  logic [2:0]                      cnt;
  logic [2:0]                      lcls;
  logic [15:0]                     hacc;
  logic                            hipend;
  logic                            bad;
  logic [6:0]                      cfg_depth;
  logic [31:0]                     cfg_bytes;
  string                           lit_words[3] = '{"true", "false", "null"};

  jsv_pkg::status_t exp_status[$];
  int      errors, n_beats, n_results, n_accept, n_reject, n_docs;
  int      snd_idle, rcv_idle;

  function automatic bit ws_char(input logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0A, 8'h0D};
  endfunction

  function automatic bit dec_char(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void doc_clear();
    pmode  = jsv_pkg::M_VALUE;
    kinds  = '0;
    depth  = 0;
    nbytes = '0;
    cnt    = '0;
    lcls   = '0;
    hacc   = '0;
    hipend = 1'b0;
    bad    = 1'b0;
  endfunction

  function automatic void push_kind(input logic obj);
    if (depth + 1 > cfg_depth || depth >= jsv_pkg::STACK_DEPTH) begin
      bad = 1'b1;
      return;
    end
    kinds[depth] = obj;
    depth++;
    pmode = obj ? jsv_pkg::M_OBJ_FIRST : jsv_pkg::M_ARR_FIRST;
  endfunction

  function automatic void pop_kind(input logic obj);
    if (depth == 0 || kinds[depth-1] != obj) begin
      bad = 1'b1;
      return;
    end
    depth--;
    pmode = jsv_pkg::M_AFTER;
  endfunction

  function automatic void open_string(input logic [4:0] k);
    pmode  = jsv_pkg::mode_t'(jsv_pkg::S_CHAR | k);
    hipend = 1'b0;
  endfunction

  function automatic void begin_value(input logic [7:0] b);
    if (b == "{") push_kind(1'b1);
    else if (b == "[") push_kind(1'b0);
    else if (b == QUOTE) open_string(5'd0);
    else if (b inside {"t", "f", "n"}) begin
      pmode = jsv_pkg::M_LIT;
      lcls  = (b == "t") ? 3'd0 : (b == "f") ? 3'd1 : 3'd2;
      cnt   = 3'd1;
    end
    else if (b == "-") pmode = jsv_pkg::N_MINUS;
    else if (b == "0") pmode = jsv_pkg::N_ZERO;
    else if (dec_char(b)) pmode = jsv_pkg::N_INT;
    else bad = 1'b1;
  endfunction

  function automatic void after_byte(input logic [7:0] b);
    if (ws_char(b)) return;
    if (depth == 0) begin
      bad = 1'b1;
      return;
    end
    if (b == ",") pmode = kinds[depth-1] ? jsv_pkg::M_KEY : jsv_pkg::M_VALUE;
    else if (b == "}") pop_kind(1'b1);
    else if (b == "]") pop_kind(1'b0);
    else bad = 1'b1;
  endfunction

  function automatic void number_step(input logic [7:0] b);
    bit ends;
    ends = 0;
    case (pmode)
      jsv_pkg::N_MINUS: begin
        if (b == "0") pmode = jsv_pkg::N_ZERO;
        else if (dec_char(b)) pmode = jsv_pkg::N_INT;
        else bad = 1'b1;
      end
      jsv_pkg::N_ZERO, jsv_pkg::N_INT: begin
        if (dec_char(b)) begin
          if (pmode == jsv_pkg::N_ZERO) bad = 1'b1;
        end
        else if (b == ".") pmode = jsv_pkg::N_DOT;
        else if (b inside {"e", "E"}) pmode = jsv_pkg::N_EXP;
        else ends = 1;
      end
      jsv_pkg::N_DOT: if (dec_char(b)) pmode = jsv_pkg::N_FRAC; else bad = 1'b1;
      jsv_pkg::N_FRAC: begin
        if (b inside {"e", "E"}) pmode = jsv_pkg::N_EXP;
        else if (!dec_char(b)) ends = 1;
      end
      jsv_pkg::N_EXP: begin
        if (b inside {"+", "-"}) pmode = jsv_pkg::N_EXP_SIGN;
        else if (dec_char(b)) pmode = jsv_pkg::N_EXP_DIG;
        else bad = 1'b1;
      end
      jsv_pkg::N_EXP_SIGN: if (dec_char(b)) pmode = jsv_pkg::N_EXP_DIG; else bad = 1'b1;
      default: if (!dec_char(b)) ends = 1;
    endcase
    // the terminating byte belongs to whatever follows the number
    if (ends) begin
      pmode = jsv_pkg::M_AFTER;
      after_byte(b);
    end
  endfunction

  function automatic void string_step(input logic [7:0] b);
    logic [4:0]     k;
    jsv_pkg::mode_t sub;
    logic [7:0]     lo, hi;
    logic [3:0]     nib;
    k   = pmode & 5'd8;
    sub = jsv_pkg::mode_t'(pmode & ~5'd8);
    case (sub)
      jsv_pkg::S_CHAR: begin
        if (b == QUOTE) pmode = (k != 0) ? jsv_pkg::M_COLON : jsv_pkg::M_AFTER;
        else if (b == BSL) pmode = jsv_pkg::mode_t'(jsv_pkg::S_ESC | k);
        else if (b < 8'h20) bad = 1'b1;
        else if (b < 8'h80) ;
        else if (b >= 8'hC2 && b <= 8'hDF) begin
          cnt = 3'd1; lcls = 3'd0; pmode = jsv_pkg::mode_t'(jsv_pkg::S_UTF8 | k);
        end
        else if (b >= 8'hE0 && b <= 8'hEF) begin
          cnt = 3'd2; lcls = (b == 8'hE0) ? 3'd1 : (b == 8'hED) ? 3'd2 : 3'd0;
          pmode = jsv_pkg::mode_t'(jsv_pkg::S_UTF8 | k);
        end
        else if (b >= 8'hF0 && b <= 8'hF4) begin
          cnt = 3'd3; lcls = (b == 8'hF0) ? 3'd3 : (b == 8'hF4) ? 3'd4 : 3'd0;
          pmode = jsv_pkg::mode_t'(jsv_pkg::S_UTF8 | k);
        end
        else bad = 1'b1;
      end
      jsv_pkg::S_UTF8: begin
        lo = 8'h80; hi = 8'hBF;
        case (lcls)
          3'd1: lo = 8'hA0;
          3'd2: hi = 8'h9F;
          3'd3: lo = 8'h90;
          3'd4: hi = 8'h8F;
          default: ;
        endcase
        if (b < lo || b > hi) bad = 1'b1;
        else begin
          lcls = 3'd0;
          cnt  = cnt - 3'd1;
          if (cnt == 0) pmode = jsv_pkg::mode_t'(jsv_pkg::S_CHAR | k);
        end
      end
      jsv_pkg::S_ESC: begin
        if (b inside {QUOTE, BSL, "/", "b", "f", "n", "r", "t"})
          pmode = jsv_pkg::mode_t'(jsv_pkg::S_CHAR | k);
        else if (b == "u") begin
          cnt = 3'd0; hacc = '0; pmode = jsv_pkg::mode_t'(jsv_pkg::S_HEX | k);
        end
        else bad = 1'b1;
      end
      jsv_pkg::S_HEX: begin
        if (dec_char(b)) nib = 4'(b - "0");
        else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 10);
        else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 10);
        else begin
          bad = 1'b1;
          return;
        end
        hacc = {hacc[11:0], nib};
        cnt  = cnt + 3'd1;
        if (cnt == 3'd4) begin
          cnt = 3'd0;
          if (hipend) begin
            if (hacc >= 16'hDC00 && hacc <= 16'hDFFF) begin
              hipend = 1'b0; pmode = jsv_pkg::mode_t'(jsv_pkg::S_CHAR | k);
            end
            else bad = 1'b1;
          end
          else if (hacc >= 16'hD800 && hacc <= 16'hDBFF) begin
            hipend = 1'b1; pmode = jsv_pkg::mode_t'(jsv_pkg::S_LOW_BS | k);
          end
          else if (hacc >= 16'hDC00 && hacc <= 16'hDFFF) bad = 1'b1;
          else pmode = jsv_pkg::mode_t'(jsv_pkg::S_CHAR | k);
        end
      end
      jsv_pkg::S_LOW_BS:
        if (b == BSL) pmode = jsv_pkg::mode_t'(jsv_pkg::S_LOW_U | k); else bad = 1'b1;
      jsv_pkg::S_LOW_U: begin
        if (b == "u") begin
          cnt = 3'd0; hacc = '0; pmode = jsv_pkg::mode_t'(jsv_pkg::S_HEX | k);
        end
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
  endfunction

  function automatic void grammar_step(input logic [7:0] b);
    if (pmode >= jsv_pkg::S_CHAR) begin
      string_step(b);
      return;
    end
    if (pmode >= jsv_pkg::N_MINUS && pmode <= jsv_pkg::N_EXP_DIG) begin
      number_step(b);
      return;
    end
    case (pmode)
      jsv_pkg::M_VALUE: if (!ws_char(b)) begin_value(b);
      jsv_pkg::M_ARR_FIRST: begin
        if (!ws_char(b)) begin
          if (b == "]") pop_kind(1'b0); else begin_value(b);
        end
      end
      jsv_pkg::M_OBJ_FIRST, jsv_pkg::M_KEY: begin
        if (!ws_char(b)) begin
          if (b == QUOTE) open_string(5'd8);
          else if (b == "}" && pmode == jsv_pkg::M_OBJ_FIRST) pop_kind(1'b1);
          else bad = 1'b1;
        end
      end
      jsv_pkg::M_COLON: if (!ws_char(b)) begin
        if (b == ":") pmode = jsv_pkg::M_VALUE; else bad = 1'b1;
      end
      jsv_pkg::M_AFTER: after_byte(b);
      jsv_pkg::M_LIT: begin
        if (lcls > 2 || cnt >= lit_words[lcls].len() || b != lit_words[lcls][cnt]) bad = 1'b1;
        else begin
          cnt = cnt + 3'd1;
          if (cnt == lit_words[lcls].len()) begin
            cnt = 3'd0; lcls = 3'd0; pmode = jsv_pkg::M_AFTER;
          end
        end
      end
      default: bad = 1'b1;
    endcase
  endfunction

  function automatic jsv_pkg::status_t next_status(input logic [7:0] b, input logic l);
    jsv_pkg::status_t st;
    bit               complete;
    st = jsv_pkg::ST_BUSY;
    if (nbytes != '1) nbytes = nbytes + 33'd1;
    if (nbytes > {1'b0, cfg_bytes}) bad = 1'b1;
    if (!bad) grammar_step(b);
    if (l) begin
      complete = pmode inside {jsv_pkg::M_AFTER, jsv_pkg::N_ZERO, jsv_pkg::N_INT,
                               jsv_pkg::N_FRAC, jsv_pkg::N_EXP_DIG};
      st = (!bad && depth == 0 && complete) ? jsv_pkg::ST_ACCEPT : jsv_pkg::ST_REJECT;
      doc_clear();
    end
    return st;
  endfunction

  // ---------------------------------------------------------------- documents
  logic [7:0] doc[$];

  function automatic void put_byte(input logic [7:0] c);
    doc.insert(doc.size(), c);
  endfunction

  function automatic void put_ws();
    string w;
    w = " \t\n\r";
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(2, 1)) put_byte(w[$urandom_range(3)]);
  endfunction

  function automatic void put_hex4(input logic [15:0] v);
    logic [3:0] nib;
    for (int i = 3; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 10) put_byte(8'("0" + nib));
      else put_byte(8'(($urandom_range(1) ? "a" : "A") + nib - 10));
    end
  endfunction

  function automatic void put_string();
    string      esc;
    logic [7:0] c, ld;
    esc = "\"\\/bfnrt";
    put_byte(QUOTE);
    repeat ($urandom_range(6)) begin
      case ($urandom_range(9))
        4: begin put_byte(BSL); put_byte(esc[$urandom_range(7)]); end
        5: begin put_byte(BSL); put_byte("u"); put_hex4(16'($urandom)); end
        6: begin
          put_byte(BSL); put_byte("u"); put_hex4(16'($urandom_range(16'hDBFF, 16'hD800)));
          put_byte(BSL); put_byte("u"); put_hex4(16'($urandom_range(16'hDFFF, 16'hDC00)));
        end
        7: begin
          put_byte(8'($urandom_range(8'hDF, 8'hC2)));
          put_byte(8'($urandom_range(8'hBF, 8'h80)));
        end
        8: begin
          ld = 8'($urandom_range(8'hEF, 8'hE0));
          put_byte(ld);
          if (ld == 8'hE0) put_byte(8'($urandom_range(8'hBF, 8'hA0)));
          else if (ld == 8'hED) put_byte(8'($urandom_range(8'h9F, 8'h80)));
          else put_byte(8'($urandom_range(8'hBF, 8'h80)));
          put_byte(8'($urandom_range(8'hBF, 8'h80)));
        end
        9: begin
          ld = 8'($urandom_range(8'hF4, 8'hF0));
          put_byte(ld);
          if (ld == 8'hF0) put_byte(8'($urandom_range(8'hBF, 8'h90)));
          else if (ld == 8'hF4) put_byte(8'($urandom_range(8'h8F, 8'h80)));
          else put_byte(8'($urandom_range(8'hBF, 8'h80)));
          repeat (2) put_byte(8'($urandom_range(8'hBF, 8'h80)));
        end
        default: begin
          c = 8'($urandom_range(126, 32));
          put_byte((c == QUOTE || c == BSL) ? "a" : c);
        end
      endcase
    end
    put_byte(QUOTE);
  endfunction

  function automatic void put_number();
    if ($urandom_range(2) == 0) put_byte("-");
    if ($urandom_range(3) == 0) put_byte("0");
    else begin
      put_byte(8'($urandom_range("9", "1")));
      repeat ($urandom_range(3)) put_byte(8'($urandom_range("9", "0")));
    end
    if ($urandom_range(2) == 0) begin
      put_byte(".");
      repeat ($urandom_range(3, 1)) put_byte(8'($urandom_range("9", "0")));
    end
    if ($urandom_range(3) == 0) begin
      put_byte($urandom_range(1) ? "e" : "E");
      case ($urandom_range(2))
        0: put_byte("+");
        1: put_byte("-");
        default: ;
      endcase
      repeat ($urandom_range(2, 1)) put_byte(8'($urandom_range("9", "0")));
    end
  endfunction

  function automatic void put_value(input int lvl);
    int    pick, n;
    string w;
    pick = (lvl >= 4) ? $urandom_range(6, 2) : $urandom_range(6);
    case (pick)
      0: begin
        put_byte("{"); put_ws();
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) begin put_byte(","); put_ws(); end
          put_string(); put_ws(); put_byte(":"); put_ws();
          put_value(lvl + 1); put_ws();
        end
        put_byte("}");
      end
      1: begin
        put_byte("["); put_ws();
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) begin put_byte(","); put_ws(); end
          put_value(lvl + 1); put_ws();
        end
        put_byte("]");
      end
      2: put_string();
      3, 4: put_number();
      default: begin
        w = lit_words[$urandom_range(2)];
        for (int i = 0; i < w.len(); i++) put_byte(w[i]);
      end
    endcase
  endfunction

  function automatic void make_document();
    int r, n;
    bit objs[$];
    doc.delete();
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(6, 1)) put_byte(8'($urandom));
    end
    else if (r < 14) begin
      // deep nest, reaching past the depth limits
      n = $urandom_range(70, 1);
      repeat (n) begin
        if ($urandom_range(3) == 0) begin
          put_byte("{"); put_string(); put_byte(":"); objs.insert(objs.size(), 1'b1);
        end
        else begin
          put_byte("["); objs.insert(objs.size(), 1'b0);
        end
      end
      put_value(4);
      while (objs.size() > 0) put_byte(objs.pop_back() ? "}" : "]");
    end
    else begin
      put_ws(); put_value(0); put_ws();
    end
    r = $urandom_range(99);
    if (r < 12) doc[$urandom_range(doc.size() - 1)] = 8'($urandom);
    else if (r < 17 && doc.size() > 1) doc = doc[0 : $urandom_range(doc.size() - 2)];
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_beat(input logic [7:0] b, input logic l, input bit typed,
                           input jsv_pkg::status_t st);
    jsv_pkg::status_t p;
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = b;
    last_byte = l;
    do @(posedge clk); while (!in_ready);
    p = next_status(b, l);
    exp_status.insert(exp_status.size(), typed ? st : p);
    n_beats++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (exp_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want, got;
    want = (idx == jsv_pkg::REG_MAX_DEPTH) ? {25'd0, val[6:0]} : val;
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = 3'(idx * 4); pwdata = val;
    @(negedge clk) penable = 1'b1;
    @(negedge clk) begin psel = 1'b0; penable = 1'b0; pwrite = 1'b0; end
    if (idx == jsv_pkg::REG_MAX_DEPTH) cfg_depth = val[6:0]; else cfg_bytes = val;
    @(negedge clk) psel = 1'b1;
    @(negedge clk) penable = 1'b1;
    @(posedge clk) got = prdata;
    @(negedge clk) begin psel = 1'b0; penable = 1'b0; end
    if (got !== want) begin
      $display("%0t: register %0d read back %h, expected %h", $time, idx, got, want);
      errors++;
    end
  endtask

  always @(negedge clk) out_ready = ($urandom_range(99) >= rcv_idle);

  always @(posedge clk) begin
    jsv_pkg::status_t e;
    if (!rst && out_valid && out_ready) begin
      if (exp_status.size() == 0) begin
        $display("%0t: status beat %0d with nothing expected", $time, status);
        errors++;
      end
      else begin
        e = exp_status.pop_front();
        if (status !== e) begin
          $display("%0t: status mismatch: expected %0d, got %0d", $time, e, status);
          errors++;
        end
        n_results++;
        if (e == jsv_pkg::ST_ACCEPT) n_accept++;
        if (e == jsv_pkg::ST_REJECT) n_reject++;
      end
    end
  end

  int stall;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
    else stall++;
    if (stall >= WATCHDOG) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  typedef struct {
    logic [7:0]       b;
    logic             l;
    bit               typed;
    jsv_pkg::status_t st;
  } dir_row_t;

  dir_row_t dir_rows[20] = '{
    '{"0",   1'b1, 1, jsv_pkg::ST_ACCEPT},
    '{8'hFF, 1'b1, 1, jsv_pkg::ST_REJECT},
    '{8'h00, 1'b1, 1, jsv_pkg::ST_REJECT},
    '{"t",   1'b0, 1, jsv_pkg::ST_BUSY}, '{"r", 1'b0, 1, jsv_pkg::ST_BUSY},
    '{"u",   1'b0, 1, jsv_pkg::ST_BUSY},
    '{"e",   1'b1, 1, jsv_pkg::ST_ACCEPT},
    '{"0",   1'b0, 1, jsv_pkg::ST_BUSY}, '{"1", 1'b1, 1, jsv_pkg::ST_REJECT},  // leading zero
    '{"[",   1'b0, 1, jsv_pkg::ST_BUSY}, '{"]", 1'b1, 1, jsv_pkg::ST_ACCEPT},
    '{"{",   1'b0, 1, jsv_pkg::ST_BUSY}, '{"1", 1'b1, 1, jsv_pkg::ST_REJECT},  // bare key
    '{"-",   1'b1, 1, jsv_pkg::ST_REJECT},
    '{"1",   1'b0, 1, jsv_pkg::ST_BUSY}, '{".", 1'b1, 1, jsv_pkg::ST_REJECT},  // bare point
    '{QUOTE, 1'b0, 0, jsv_pkg::ST_BUSY}, '{8'hC3, 1'b0, 0, jsv_pkg::ST_BUSY},
    '{8'hA9, 1'b0, 0, jsv_pkg::ST_BUSY},
    '{QUOTE, 1'b1, 0, jsv_pkg::ST_BUSY}
  };

  logic [6:0]  ph_depth[N_PHASES] = '{7'd64, 7'd0, 7'd127, 7'd2, 7'd16, 7'd64};
  logic [31:0] ph_bytes[N_PHASES] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd24, 32'd0, 32'd300,
                                      32'hFFFF_FFFF};

  initial begin
    int phase_beats;
    rst = 1'b1; in_valid = 1'b0; data_byte = '0; last_byte = 1'b0; out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; n_beats = 0; n_results = 0; n_accept = 0; n_reject = 0; n_docs = 0;
    snd_idle = 17; rcv_idle = 71;
    cfg_depth = 7'd64; cfg_bytes = 32'hFFFF_FFFF;
    doc_clear();
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].st);

    // last phase goes past the stack size with a large depth limit
    ph_depth[N_PHASES-1] = 7'($urandom_range(127, 65));
    ph_bytes[N_PHASES-1] = 32'hFFFF_FFFF - $urandom_range(1000);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph / 2)
        0: begin snd_idle = 17; rcv_idle = 71; end
        1: begin snd_idle = 71; rcv_idle = 17; end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      reg_write(jsv_pkg::REG_MAX_DEPTH, {25'd0, ph_depth[ph]});
      reg_write(jsv_pkg::REG_MAX_BYTES, ph_bytes[ph]);
      phase_beats = 0;
      while (phase_beats < RAND_BEATS / N_PHASES) begin
        make_document();
        foreach (doc[i]) send_beat(doc[i], i == doc.size() - 1, 0, jsv_pkg::ST_BUSY);
        phase_beats += doc.size();
        n_docs++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Ran %0d byte beats over %0d random documents and %0d limit settings.",
             n_beats, n_docs, N_PHASES);
    $display("Status beats checked: %0d (%0d accepted, %0d rejected), mismatches: %0d.",
             n_results, n_accept, n_reject, errors);
    if (errors == 0 && exp_status.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
